>>> rtl/core/boundary_tag_first_fit_allocator_defines.svh
// Assertion macros for the allocator core.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BTTF_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bttf assertion failed");
`define BTTF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bttf assertion failed");
`else
`define BTTF_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define BTTF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/bttf_pkg.sv
package bttf_pkg;

  localparam int HEAP_BYTES_DEFAULT = 65536;
  localparam logic [16:0] CHUNK_RESET = 17'd4096;
  localparam int MIN_SPLIT = 16;

  localparam logic [31:0] PROLOGUE_TAG = 32'h7;
  localparam logic [31:0] EPILOGUE_TAG = 32'h3;
  localparam logic [31:0] END_TAG      = 32'h1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

endpackage

>>> rtl/core/bttf_ram.sv
module bttf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/boundary_tag_first_fit_allocator.sv
// Boundary-tag first-fit heap allocator.
// Input channel (in_valid/in_stall): one beat carries action, request_bytes
// and block_address. Output channel (out_valid/out_stall): one beat per
// request with result_address and status (0 done, 1 ignored, 2 out of memory).
// cfg_write loads chunk_bytes, the heap growth step; write only while idle.
// One request is worked at a time; all tag words live in a RAM whose read
// data is registered and whose read and write share one address.
// After dispatch, an allocate walks the blocks first fit and then places
// itself in the block it found, growing the heap first when no block fits;
// a free marks its block free and merges it with free neighbours. The first
// request, unless it frees address 0, also builds the heap.
// The next beat is taken once the result sits in the output register; if the
// receiver stalls, the result holds there and a finished second result waits
// inside the core until the register frees up.
// Reset (rst, synchronous) empties the heap, restores chunk_bytes to 4096 and
// drops any pending result; the tag RAM is not cleared.
`include "boundary_tag_first_fit_allocator_defines.svh"

module boundary_tag_first_fit_allocator #(
  parameter int HEAP_BYTES = bttf_pkg::HEAP_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [16:0] request_bytes,
  input  logic [15:0] block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] result_address,
  output logic [1:0]  status,
  input  logic        cfg_write,
  input  logic [16:0] chunk_bytes
);

  localparam int TAG_WORDS = HEAP_BYTES / 4;
  localparam int IW = $clog2(TAG_WORDS);
  localparam int HW = $clog2(HEAP_BYTES) + 2;
  localparam int W  = (HW > 19) ? HW : 19;

  typedef enum logic [30:0] {
    S_IDLE  = 31'd1 << 0,  S_DISP  = 31'd1 << 1,  S_B0    = 31'd1 << 2,
    S_B1    = 31'd1 << 3,  S_G0    = 31'd1 << 4,  S_G1    = 31'd1 << 5,
    S_G2    = 31'd1 << 6,  S_G3    = 31'd1 << 7,  S_M0    = 31'd1 << 8,
    S_M1    = 31'd1 << 9,  S_M2    = 31'd1 << 10, S_M3    = 31'd1 << 11,
    S_M4    = 31'd1 << 12, S_M5    = 31'd1 << 13, S_M6    = 31'd1 << 14,
    S_ALLOC = 31'd1 << 15, S_F0    = 31'd1 << 16, S_F1    = 31'd1 << 17,
    S_P0    = 31'd1 << 18, S_P1    = 31'd1 << 19, S_P2    = 31'd1 << 20,
    S_P3    = 31'd1 << 21, S_P4    = 31'd1 << 22, S_P5    = 31'd1 << 23,
    S_FREE  = 31'd1 << 24, S_Q0    = 31'd1 << 25, S_Q1    = 31'd1 << 26,
    S_Q2    = 31'd1 << 27, S_Q3    = 31'd1 << 28, S_Q4    = 31'd1 << 29,
    S_DONE  = 31'd1 << 30
  } state_t;

  state_t         state;
  logic           op;
  logic [16:0]    req;
  logic [W-1:0]   addr_w;
  logic [16:0]    chunk;
  logic [W-1:0]   heap_break;
  logic           heap_ready;
  logic [W-1:0]   bp, p, sz, nxsz, t, prv, asize, ext, csize;
  logic           pa, na, split, grow_ctx, mctx;
  logic [15:0]    res_addr;
  logic [1:0]     res_status;

  logic           mem_re, mem_we, mem_in, rd_oob;
  logic [W-1:0]   mem_addr;
  logic [31:0]    mem_wdata, ram_rdata, rdat;
  logic [W-1:0]   rsz, csz, tsum, asize_c;
  logic           grow_fail, split_c, free_bad, mret;
  logic [W-1:0]   mret_val;
  logic [31:0]    hsz32;

  function automatic logic [31:0] tagw(logic [W-1:0] s, logic pb, logic ab);
    tagw = 32'(s) | {30'b0, pb, ab};
  endfunction

  assign rdat     = rd_oob ? 32'h0 : ram_rdata;
  assign rsz      = {rdat[W-1:3], 3'b000};
  assign hsz32    = {rdat[31:3], 3'b000};
  assign csz      = (chunk == 17'd0) ? W'(8) : (W'(chunk) + W'(7)) & ~W'(7);
  assign asize_c  = (req <= 17'd4) ? W'(8) : (W'(req) + W'(11)) & ~W'(7);
  assign grow_fail = (heap_break + ext) > W'(HEAP_BYTES);
  assign split_c  = rsz >= asize + W'(bttf_pkg::MIN_SPLIT);
  assign tsum     = sz + rsz + (na ? '0 : nxsz);
  assign free_bad = !rdat[0] || hsz32 < 32'd8 || hsz32 > 32'(heap_break - addr_w);
  assign mem_in   = mem_addr < W'(HEAP_BYTES);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    mret     = 1'b0;
    mret_val = bp;
    unique case (state)
      S_M2: mret = pa && rdat[0];
      S_M3: mret = 1'b1;
      S_M6: begin
        mret     = 1'b1;
        mret_val = prv;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (state)
      S_B0: begin
        mem_we = 1'b1; mem_addr = W'(0); mem_wdata = bttf_pkg::PROLOGUE_TAG;
      end
      S_B1: begin
        mem_we = 1'b1; mem_addr = W'(4); mem_wdata = bttf_pkg::EPILOGUE_TAG;
      end
      S_G0: begin
        mem_re = !grow_fail; mem_addr = heap_break - W'(4);
      end
      S_G1: begin
        mem_we = 1'b1; mem_addr = bp - W'(4); mem_wdata = tagw(ext, rdat[1], 1'b0);
      end
      S_G2: begin
        mem_we = 1'b1; mem_addr = bp + ext - W'(8); mem_wdata = tagw(ext, pa, 1'b0);
      end
      S_G3: begin
        mem_we = 1'b1; mem_addr = bp + ext - W'(4); mem_wdata = bttf_pkg::END_TAG;
      end
      S_M0: begin
        mem_re = 1'b1; mem_addr = bp - W'(4);
      end
      S_M1: begin
        mem_re = 1'b1; mem_addr = bp + rsz - W'(4);
      end
      S_M2: begin
        if (!(pa && rdat[0])) begin
          if (pa) begin
            mem_we = 1'b1; mem_addr = bp - W'(4);
            mem_wdata = tagw(sz + rsz, 1'b1, 1'b0);
          end else begin
            mem_re = 1'b1; mem_addr = bp - W'(8);
          end
        end
      end
      S_M3: begin
        mem_we = 1'b1; mem_addr = bp + t - W'(8); mem_wdata = tagw(t, 1'b1, 1'b0);
      end
      S_M4: begin
        mem_re = 1'b1; mem_addr = bp - rsz - W'(4);
      end
      S_M5: begin
        mem_we = 1'b1; mem_addr = prv - W'(4); mem_wdata = tagw(tsum, rdat[1], 1'b0);
      end
      S_M6: begin
        mem_we = 1'b1; mem_addr = prv + t - W'(8); mem_wdata = tagw(t, pa, 1'b0);
      end
      S_F0: begin
        mem_re = p < heap_break; mem_addr = p - W'(4);
      end
      S_P0: begin
        mem_re = 1'b1; mem_addr = bp - W'(4);
      end
      S_P1: begin
        mem_we = 1'b1; mem_addr = bp - W'(4);
        mem_wdata = tagw(split_c ? asize : rsz, rdat[1], 1'b1);
      end
      S_P2: begin
        mem_we = 1'b1; mem_addr = bp + asize - W'(4);
        mem_wdata = tagw(csize - asize, 1'b1, 1'b0);
      end
      S_P3: begin
        mem_we = 1'b1; mem_addr = bp + csize - W'(8);
        mem_wdata = tagw(csize - asize, 1'b1, 1'b0);
      end
      S_P4: begin
        mem_re = 1'b1; mem_addr = bp + csize - W'(4);
      end
      S_P5: begin
        mem_we = 1'b1; mem_addr = bp + csize - W'(4);
        mem_wdata = split ? (rdat & ~32'h2) : (rdat | 32'h2);
      end
      S_Q0: begin
        mem_re = 1'b1; mem_addr = addr_w - W'(4);
      end
      S_Q1: begin
        mem_we = !free_bad; mem_addr = addr_w - W'(4);
        mem_wdata = tagw(rsz, rdat[1], 1'b0);
      end
      S_Q2: begin
        mem_we = 1'b1; mem_addr = bp + sz - W'(8); mem_wdata = tagw(sz, pa, 1'b0);
      end
      S_Q3: begin
        mem_re = 1'b1; mem_addr = bp + sz - W'(4);
      end
      S_Q4: begin
        mem_we = 1'b1; mem_addr = bp + sz - W'(4); mem_wdata = rdat & ~32'h2;
      end
      default: ;
    endcase
  end

  bttf_ram #(
    .WIDTH (32),
    .DEPTH (TAG_WORDS)
  ) u_tags (
    .clk   (clk),
    .we    (mem_we && mem_in),
    .waddr (mem_addr[IW+1:2]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr[IW+1:2]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_oob <= !mem_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heap_break <= '0;
      heap_ready <= 1'b0;
      chunk      <= bttf_pkg::CHUNK_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        chunk <= chunk_bytes;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= action;
            req    <= request_bytes;
            addr_w <= W'(block_address);
            state  <= S_DISP;
          end
        end
        S_DISP: begin
          if (op == bttf_pkg::ACT_FREE && addr_w == '0) begin
            res_addr <= '0; res_status <= bttf_pkg::ST_IGNORED; state <= S_DONE;
          end else if (!heap_ready) begin
            state <= S_B0;
          end else begin
            state <= (op == bttf_pkg::ACT_FREE) ? S_FREE : S_ALLOC;
          end
        end
        S_B0: state <= S_B1;
        S_B1: begin
          heap_break <= W'(8);
          heap_ready <= 1'b1;
          ext        <= csz;
          grow_ctx   <= 1'b0;
          state      <= S_G0;
        end
        S_G0: begin
          if (grow_fail) begin
            if (grow_ctx) begin
              res_addr <= '0; res_status <= bttf_pkg::ST_NO_MEMORY; state <= S_DONE;
            end else begin
              state <= (op == bttf_pkg::ACT_FREE) ? S_FREE : S_ALLOC;
            end
          end else begin
            bp         <= heap_break;
            heap_break <= heap_break + ext;
            state      <= S_G1;
          end
        end
        S_G1: begin
          pa    <= rdat[1];
          state <= S_G2;
        end
        S_G2: state <= S_G3;
        S_G3: begin
          mctx  <= 1'b0;
          state <= S_M0;
        end
        S_M0: state <= S_M1;
        S_M1: begin
          sz    <= rsz;
          pa    <= rdat[1];
          state <= S_M2;
        end
        S_M2: begin
          na   <= rdat[0];
          nxsz <= rsz;
          t    <= sz + rsz;
          if (!(pa && rdat[0])) begin
            state <= pa ? S_M3 : S_M4;
          end
        end
        S_M4: begin
          prv   <= bp - rsz;
          state <= S_M5;
        end
        S_M5: begin
          t     <= tsum;
          pa    <= rdat[1];
          state <= S_M6;
        end
        S_ALLOC: begin
          if (req == 17'd0) begin
            res_addr <= '0; res_status <= bttf_pkg::ST_IGNORED; state <= S_DONE;
          end else begin
            asize <= asize_c;
            p     <= W'(8);
            state <= S_F0;
          end
        end
        S_F0: begin
          if (p < heap_break) begin
            state <= S_F1;
          end else begin
            ext      <= (asize > csz) ? asize : csz;
            grow_ctx <= 1'b1;
            state    <= S_G0;
          end
        end
        S_F1: begin
          if (rsz == '0) begin
            ext      <= (asize > csz) ? asize : csz;
            grow_ctx <= 1'b1;
            state    <= S_G0;
          end else if (!rdat[0] && asize <= rsz) begin
            bp    <= p;
            state <= S_P0;
          end else begin
            p     <= p + rsz;
            state <= S_F0;
          end
        end
        S_P0: state <= S_P1;
        S_P1: begin
          csize <= rsz;
          split <= split_c;
          state <= split_c ? S_P2 : S_P4;
        end
        S_P2: state <= S_P3;
        S_P3: state <= S_P4;
        S_P4: state <= S_P5;
        S_P5: begin
          res_addr   <= bp[15:0];
          res_status <= bttf_pkg::ST_DONE;
          state      <= S_DONE;
        end
        S_FREE: begin
          if (addr_w[2:0] != 3'b000 || addr_w >= heap_break) begin
            res_addr <= '0; res_status <= bttf_pkg::ST_IGNORED; state <= S_DONE;
          end else begin
            state <= S_Q0;
          end
        end
        S_Q0: state <= S_Q1;
        S_Q1: begin
          if (free_bad) begin
            res_addr <= '0; res_status <= bttf_pkg::ST_IGNORED; state <= S_DONE;
          end else begin
            sz    <= rsz;
            pa    <= rdat[1];
            bp    <= addr_w;
            state <= S_Q2;
          end
        end
        S_Q2: state <= S_Q3;
        S_Q3: state <= S_Q4;
        S_Q4: begin
          mctx  <= 1'b1;
          state <= S_M0;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            result_address <= res_addr;
            status         <= res_status;
            state          <= S_IDLE;
          end
        end
        default: ;
      endcase
      if (mret) begin
        if (mctx) begin
          res_addr <= '0; res_status <= bttf_pkg::ST_DONE; state <= S_DONE;
        end else if (grow_ctx) begin
          bp    <= mret_val;
          state <= S_P0;
        end else begin
          state <= (op == bttf_pkg::ACT_FREE) ? S_FREE : S_ALLOC;
        end
      end
    end
  end

  `BTTF_ASSERT_ALWAYS(a_break_cap, clk, rst, heap_break <= W'(HEAP_BYTES))
  `BTTF_ASSERT_ALWAYS(a_break_built, clk, rst, heap_ready || heap_break == '0)
  `BTTF_ASSERT_NEXT(a_ready_sticks, clk, rst, heap_ready, heap_ready)
  `BTTF_ASSERT_ALWAYS(a_out_align, clk, rst, !out_valid || result_address[2:0] == 3'b000)

endmodule

>>> verif/boundary_tag_first_fit_allocator_tb.sv
`timescale 1ns / 100ps

module boundary_tag_first_fit_allocator_tb;

  localparam int HEAP = bttf_pkg::HEAP_BYTES_DEFAULT;
  localparam int WORDS = HEAP / 4;
  localparam int STALL_LEN = 400;
  localparam int WDOG_LIMIT = 200000;

  typedef struct {
    logic        act;
    logic [16:0] req;
    logic [15:0] addr;
  } request_t;

  typedef struct {
    logic [15:0] addr;
    logic [1:0]  st;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = bttf_pkg::ACT_ALLOC;
  logic [16:0] request_bytes = '0;
  logic [15:0] block_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] result_address;
  logic [1:0]  status;
  logic        cfg_write = 1'b0;
  logic [16:0] chunk_bytes = bttf_pkg::CHUNK_RESET;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  longint unsigned live_blocks[$];
  int errors = 0;
  int sent_cnt = 0;
  int recv_cnt = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit held_once = 0;

  // shadow heap
  logic [31:0]     heap_tags[WORDS];
  longint unsigned heap_brk = 0;
  bit              heap_built = 0;
  logic [16:0]     grow_step = bttf_pkg::CHUNK_RESET;

  boundary_tag_first_fit_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .request_bytes(request_bytes), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_address(result_address), .status(status),
    .cfg_write(cfg_write), .chunk_bytes(chunk_bytes)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned tag_rd(longint unsigned a);
    return ((a >> 2) < WORDS) ? longint'(heap_tags[a >> 2]) : 0;
  endfunction

  function automatic void tag_wr(longint unsigned a, longint unsigned v);
    if ((a >> 2) < WORDS) heap_tags[a >> 2] = v[31:0];
  endfunction

  function automatic longint unsigned blk_size(longint unsigned bp);
    return tag_rd(bp - 4) & ~64'd7;
  endfunction

  function automatic longint unsigned blk_prev(longint unsigned bp);
    return (tag_rd(bp - 4) >> 1) & 1;
  endfunction

  function automatic longint unsigned blk_used(longint unsigned bp);
    return tag_rd(bp - 4) & 1;
  endfunction

  function automatic longint unsigned grow_unit();
    longint unsigned c;
    c = (longint'(grow_step) + 7) & ~64'd7;
    return (c == 0) ? 8 : c;
  endfunction

  function automatic longint unsigned coalesce(longint unsigned bp);
    longint unsigned sz, nx, pa, na, prv, ppa, t;
    sz = blk_size(bp);
    nx = bp + sz;
    pa = blk_prev(bp);
    na = blk_used(nx);
    if (pa && na) return bp;
    if (pa) begin
      t = sz + blk_size(nx);
      tag_wr(bp - 4, t | 2);
      tag_wr(bp + t - 8, t | 2);
      return bp;
    end
    prv = bp - (tag_rd(bp - 8) & ~64'd7);
    ppa = blk_prev(prv);
    t = sz + blk_size(prv);
    if (!na) t += blk_size(nx);
    tag_wr(prv - 4, t | (ppa << 1));
    tag_wr(prv + t - 8, t | (ppa << 1));
    return prv;
  endfunction

  function automatic longint unsigned grow_heap_by(longint unsigned bytes);
    longint unsigned bp, pa;
    bp = heap_brk;
    if (bp + bytes > HEAP) return 0;
    heap_brk = bp + bytes;
    pa = blk_prev(bp);
    tag_wr(bp - 4, bytes | (pa << 1));
    tag_wr(bp + bytes - 8, bytes | (pa << 1));
    tag_wr(bp + bytes - 4, 1);
    return coalesce(bp);
  endfunction

  function automatic void build_heap();
    longint unsigned dummy;
    tag_wr(0, bttf_pkg::PROLOGUE_TAG);
    tag_wr(4, bttf_pkg::EPILOGUE_TAG);
    heap_brk = 8;
    heap_built = 1;
    dummy = grow_heap_by(grow_unit());
  endfunction

  function automatic longint unsigned scan_first_fit(longint unsigned asz);
    longint unsigned p, sz;
    p = 8;
    while (p < heap_brk) begin
      sz = blk_size(p);
      if (sz == 0) return 0;
      if (!blk_used(p) && asz <= sz) return p;
      p += sz;
    end
    return 0;
  endfunction

  function automatic void carve(longint unsigned bp, longint unsigned asz);
    longint unsigned csz, pa, nx, rest;
    csz = blk_size(bp);
    pa = blk_prev(bp);
    nx = bp + csz;
    if (csz - asz >= bttf_pkg::MIN_SPLIT) begin
      rest = csz - asz;
      tag_wr(bp - 4, asz | (pa << 1) | 1);
      tag_wr(bp + asz - 4, rest | 2);
      tag_wr(bp + csz - 8, rest | 2);
      tag_wr(nx - 4, tag_rd(nx - 4) & ~64'd2);
    end else begin
      tag_wr(bp - 4, csz | (pa << 1) | 1);
      tag_wr(nx - 4, tag_rd(nx - 4) | 2);
    end
  endfunction

  function automatic reply_t serve_request(request_t r);
    reply_t o;
    longint unsigned asz, bp, ext, a, hdr, sz, pa, nx;
    o.addr = '0;
    o.st = bttf_pkg::ST_IGNORED;
    a = r.addr;
    if (r.act == bttf_pkg::ACT_ALLOC) begin
      if (!heap_built) build_heap();
      if (r.req == 0) return o;
      asz = (r.req <= 4) ? 8 : 8 * ((longint'(r.req) + 11) / 8);
      bp = scan_first_fit(asz);
      if (bp == 0) begin
        ext = (asz > grow_unit()) ? asz : grow_unit();
        bp = grow_heap_by(ext);
        if (bp == 0) begin
          o.st = bttf_pkg::ST_NO_MEMORY;
          return o;
        end
      end
      carve(bp, asz);
      o.addr = bp[15:0];
      o.st = bttf_pkg::ST_DONE;
    end else begin
      if (a == 0) return o;
      if (!heap_built) build_heap();
      if ((a & 7) != 0 || a >= heap_brk) return o;
      hdr = tag_rd(a - 4);
      sz = hdr & ~64'd7;
      if ((hdr & 1) == 0 || sz < 8 || a + sz > heap_brk) return o;
      pa = (hdr >> 1) & 1;
      tag_wr(a - 4, sz | (pa << 1));
      tag_wr(a + sz - 8, sz | (pa << 1));
      nx = a + sz;
      tag_wr(nx - 4, tag_rd(nx - 4) & ~64'd2);
      a = coalesce(a);
      o.st = bttf_pkg::ST_DONE;
    end
    return o;
  endfunction

  task automatic issue(logic act, logic [16:0] req, logic [15:0] addr);
    request_t r;
    reply_t o;
    r.act = act;
    r.req = req;
    r.addr = addr;
    o = serve_request(r);
    if (act == bttf_pkg::ACT_ALLOC && o.st == bttf_pkg::ST_DONE)
      live_blocks.push_back(o.addr);
    if (act == bttf_pkg::ACT_FREE && o.st == bttf_pkg::ST_DONE)
      foreach (live_blocks[i])
        if (live_blocks[i] == addr) begin
          live_blocks.delete(i);
          break;
        end
    pending_reqs.push_back(r);
    expected_replies.push_back(o);
  endtask

  task automatic free_nth(int n);
    if (live_blocks.size() > n) issue(bttf_pkg::ACT_FREE, '0, live_blocks[n][15:0]);
  endtask

  function automatic logic [15:0] pick_block_start();
    longint unsigned starts[$];
    longint unsigned p;
    p = 8;
    while (p < heap_brk && blk_size(p) != 0) begin
      starts.push_back(p);
      p += blk_size(p);
    end
    if (starts.size() == 0) return 16'd0;
    return starts[$urandom_range(starts.size() - 1)][15:0];
  endfunction

  task automatic random_item();
    int r, k;
    logic [16:0] sz;
    r = $urandom_range(99);
    if (r < 55) begin
      k = $urandom_range(99);
      if (k < 2) sz = '0;
      else if (k < 5) sz = 17'($urandom_range(65536, 1));
      else if (k < 15) sz = 17'($urandom_range(8192, 1));
      else sz = 17'($urandom_range(256, 1));
      issue(bttf_pkg::ACT_ALLOC, sz, '0);
    end else begin
      k = $urandom_range(99);
      if (!heap_built || k < 8)
        issue(bttf_pkg::ACT_FREE, '0, 16'($urandom_range(65535) | 1));
      else if (k < 15) issue(bttf_pkg::ACT_FREE, '0, '0);
      else if (k < 22 && heap_brk < HEAP)
        issue(bttf_pkg::ACT_FREE, '0,
              16'($urandom_range(HEAP - 1, 32'(heap_brk)) & ~32'd7));
      else if (k < 32) issue(bttf_pkg::ACT_FREE, '0, pick_block_start());
      else if (live_blocks.size() > 0) free_nth($urandom_range(live_blocks.size() - 1));
      else issue(bttf_pkg::ACT_ALLOC, 17'($urandom_range(64, 1)), '0);
    end
  endtask

  task automatic set_chunk(logic [16:0] v);
    while (pending_reqs.size() != 0 || expected_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_write <= 1'b1;
    chunk_bytes <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    grow_step = v;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) sent_cnt <= sent_cnt + 1;
      if (pending_reqs.size() != 0 &&
          ((sent_cnt > 300 && sent_cnt < 400) || $urandom_range(99) >= 13)) begin
        {action, request_bytes, block_address} <=
          {pending_reqs[0].act, pending_reqs[0].req, pending_reqs[0].addr};
        void'(pending_reqs.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!held_once && recv_cnt == 150) begin
      held_once <= 1'b1;
      stall_left <= STALL_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(recv_cnt > 300 && recv_cnt < 400) && ($urandom_range(99) < 13);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      recv_cnt <= recv_cnt + 1;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected beat addr=%0d status=%0d", $time, result_address, status);
        errors++;
      end else begin
        if (result_address !== expected_replies[0].addr) begin
          $display("%0t: result_address expected %0d actual %0d", $time,
                   expected_replies[0].addr, result_address);
          errors++;
        end
        if (status !== expected_replies[0].st) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   expected_replies[0].st, status);
          errors++;
        end
        void'(expected_replies.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [16:0] phases[5];
    phases = '{17'd8, 17'd65536, 17'd100, 17'd1, 17'd4096};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    issue(bttf_pkg::ACT_FREE, '0, 16'hFFFF);
    issue(bttf_pkg::ACT_ALLOC, '0, '0);
    issue(bttf_pkg::ACT_FREE, '0, '0);
    issue(bttf_pkg::ACT_ALLOC, 17'd1, '0);
    issue(bttf_pkg::ACT_ALLOC, 17'd4, '0);
    issue(bttf_pkg::ACT_ALLOC, 17'd5, '0);
    issue(bttf_pkg::ACT_ALLOC, 17'd12, '0);
    issue(bttf_pkg::ACT_ALLOC, 17'd13, '0);
    issue(bttf_pkg::ACT_ALLOC, 17'd65536, '0);
    issue(bttf_pkg::ACT_ALLOC, 17'd65535, '0);
    issue(bttf_pkg::ACT_FREE, '0, 16'd65528);
    issue(bttf_pkg::ACT_FREE, '0, 16'd12);
    free_nth(0);
    issue(bttf_pkg::ACT_FREE, '0, 16'd8);
    free_nth(1);
    free_nth(0);
    issue(bttf_pkg::ACT_ALLOC, 17'd4000, '0);
    issue(bttf_pkg::ACT_ALLOC, 17'd9000, '0);
    free_nth(0);
    free_nth(0);
    issue(bttf_pkg::ACT_ALLOC, 17'd20, '0);

    foreach (phases[p]) begin
      set_chunk(phases[p]);
      for (int i = 0; i < 120; i++) random_item();
    end

    while (pending_reqs.size() != 0 || expected_replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> boundary_tag_first_fit_allocator.f
+incdir+rtl/core
rtl/core/bttf_pkg.sv
rtl/core/bttf_ram.sv
rtl/core/boundary_tag_first_fit_allocator.sv
verif/boundary_tag_first_fit_allocator_tb.sv
